// ===== src/sdtt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtt_pkg: shared types and constants for the moving-average trade trigger
// Widths of the channel fields, register reset values, queue sizing and the
// word format that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package sdtt_pkg;

  // Window length and field widths.
  localparam int WINDOW     = 20;
  localparam int PRICE_W    = 24;
  localparam int TICK_W     = 64;
  localparam int POS_W      = 21;
  localparam int THR_W      = 20;
  localparam int SIZE_W     = 16;
  localparam int MAXPOS_W   = 20;
  localparam int COOL_W     = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Derived widths: print count, running sum, scaled threshold, deviation.
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = PRICE_W + $clog2(WINDOW);
  localparam int LIM_W = THR_W + $clog2(WINDOW);
  localparam int DEV_W = ((SUM_W > LIM_W) ? SUM_W : LIM_W) + 2;

  // Queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register reset values.
  localparam int THR_RST    = 10;
  localparam int SIZE_RST   = 50;
  localparam int MAXPOS_RST = 500;
  localparam int COOL_RST   = 5;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD    = 3'd0,
    CFG_TRADE_SIZE   = 3'd1,
    CFG_MAX_POSITION = 3'd2,
    CFG_COOLDOWN     = 3'd3
  } cfg_reg_e;

  // Operation carried by one queued word.
  typedef enum logic {
    OP_PRINT = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  // Order side codes.
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // Classified word handed from the front part to the back part.
  typedef struct packed {
    op_e                      op;
    logic [PRICE_W-1:0]       price;
    logic [SUM_W-1:0]         price_x;   // price times WINDOW
    logic [TICK_W-1:0]        tick;
    logic signed [POS_W-1:0]  position;
  } q_word_t;

endpackage

// ===== src/sdtt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtt_if: channel interfaces of the trade trigger
// Input channel with price prints and tick events, and the order channel.
// Both use a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdtt_in_if import sdtt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [PRICE_W-1:0]       price;
  logic [TICK_W-1:0]        tick_number;
  logic signed [POS_W-1:0]  position;

  modport source (output valid, output cmd, output price, output tick_number,
                  output position, input ready);
  modport sink   (input valid, input cmd, input price, input tick_number,
                  input position, output ready);
endinterface

interface sdtt_out_if import sdtt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              side;
  logic [SIZE_W-1:0] quantity;

  modport source (output valid, output side, output quantity, input ready);
  modport sink   (input valid, input side, input quantity, output ready);
endinterface

// ===== src/sma_deviation_trade_trigger.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_deviation_trade_trigger: moving-average deviation trade trigger
// Input words carry either a price print (cmd 0) or a tick event (cmd 1).
// Prints fill a window of the last WINDOW prices with a running sum. A tick,
// once the window is full and the cooldown since the last trade has passed,
// compares the latest price with the window mean and emits a buy or sell
// order word of trade_size shares when the deviation clears the threshold
// and the position cap allows it.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0 threshold, 1 trade_size, 2 max_position, 3 cooldown); the user writes
// only while idle, which the block itself does not enforce. An order word
// passes the front register, the queue and the output register. Throughput:
// one input word per cycle, unless a tick waits on a stalled order output.
// Reset clears the window count, running sum and trade history and loads
// the register defaults; no clearing pass is needed.
// When the order receiver stalls, the held order waits in the output
// register; prints keep flowing, and a following tick waits in the queue,
// which fills and then stops input acceptance.
// ----------------------------------------------------------------------------
module sma_deviation_trade_trigger import sdtt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sdtt_in_if.sink               in_i,
  sdtt_out_if.source            out_o
);

  logic    push_valid, push_ready;
  logic    pop_valid, pop_ready;
  q_word_t push_word, pop_word;

  // Front part: accept and classify.
  sdtt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_word_o  (push_word)
  );

  // Decoupling queue.
  sdtt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_word_i  (push_word),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_word_o   (pop_word)
  );

  // Back part: window state, evaluation and order output.
  sdtt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_word_i  (pop_word),
    .out_o       (out_o)
  );

endmodule

// ===== src/sdtt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtt_front: input stage of the trade trigger
// Accepts words from the input channel, decodes the command and scales the
// print price by the window length, then hands the word to the queue.
// ----------------------------------------------------------------------------
module sdtt_front import sdtt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  sdtt_in_if.sink       in_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output q_word_t       push_word_o
);

  logic    valid_d, valid_q;
  q_word_t word_d, word_q;

  // The stage takes a new word when it is empty or its word moves on.
  assign in_i.ready = !valid_q || push_ready_i;

  // Classify the incoming word.
  always_comb begin
    word_d          = word_q;
    valid_d         = valid_q;
    if (in_i.valid && in_i.ready) begin
      valid_d          = 1'b1;
      word_d.op        = in_i.cmd ? OP_TICK : OP_PRINT;
      word_d.price     = in_i.price;
      word_d.price_x   = SUM_W'(in_i.price) * SUM_W'(WINDOW);
      word_d.tick      = in_i.tick_number;
      word_d.position  = in_i.position;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // Control flop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload flops.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign push_valid_o = valid_q;
  assign push_word_o  = word_q;

endmodule

// ===== src/sdtt_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtt_queue: short queue between the front and back parts
// A small first-in first-out buffer of classified words, so that a stall of
// the back part does not stop the front part at once.
// ----------------------------------------------------------------------------
module sdtt_queue import sdtt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  input  q_word_t push_word_i,
  output logic    pop_valid_o,
  input  logic    pop_ready_i,
  output q_word_t pop_word_o
);

  q_word_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_d, wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_d, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_d, cnt_q;
  logic                push, pop;

  // Handshake on both sides.
  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_word_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Control flops.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

`ifndef NO_ASSERTIONS
  // The fill count never passes the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue fill count above depth");

  // The fill count rises by one on a push without a pop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count lost a push");
`endif

endmodule

// ===== src/sdtt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtt_back: execution part of the trade trigger
// Keeps the price window, running sum and trade history, evaluates ticks
// against mean, threshold, cooldown and position cap, and holds the order
// word in an output register. Also holds the configuration registers.
// ----------------------------------------------------------------------------
module sdtt_back import sdtt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  q_word_t               pop_word_i,
  sdtt_out_if.source            out_o
);

  // Configuration registers; the threshold is kept scaled by WINDOW.
  logic [LIM_W-1:0]     lim_d, lim_q;
  logic [SIZE_W-1:0]    size_d, size_q;
  logic [MAXPOS_W-1:0]  maxpos_d, maxpos_q;
  logic [COOL_W-1:0]    cool_d, cool_q;

  // Window state.
  logic [PRICE_W-1:0]   win_q [WINDOW];
  logic [CNT_W-1:0]     cnt_d, cnt_q;
  logic [SUM_W-1:0]     sum_d, sum_q;
  logic [SUM_W-1:0]     latest_x_d, latest_x_q;
  logic [TICK_W-1:0]    last_tick_d, last_tick_q;

  // Output register.
  logic                 out_valid_d, out_valid_q;
  logic                 side_d, side_q;
  logic [SIZE_W-1:0]    qty_d, qty_q;

  // Evaluation signals.
  logic                      take, take_print, take_tick;
  logic                      full, cool_ok, buy, sell, fire;
  logic [TICK_W-1:0]         tick_diff;
  logic signed [DEV_W-1:0]   dev, lim_s, nlim_s;
  logic signed [POS_W:0]     pos_s, cap_s, ncap_s;

  // A print never produces an order, so it does not wait for the output.
  assign pop_ready_o = (pop_word_i.op == OP_PRINT) || !out_valid_q || out_o.ready;
  assign take        = pop_valid_i && pop_ready_o;
  assign take_print  = take && (pop_word_i.op == OP_PRINT);
  assign take_tick   = take && (pop_word_i.op == OP_TICK);

  // Tick evaluation: cooldown, deviation from the mean and position cap.
  assign full      = (cnt_q == CNT_W'(WINDOW));
  assign tick_diff = pop_word_i.tick - last_tick_q;
  assign cool_ok   = (tick_diff >= TICK_W'(cool_q));
  assign dev       = $signed(DEV_W'(latest_x_q)) - $signed(DEV_W'(sum_q));
  assign lim_s     = $signed(DEV_W'(lim_q));
  assign nlim_s    = -lim_s;
  assign pos_s     = (POS_W+1)'(pop_word_i.position);
  assign cap_s     = $signed((POS_W+1)'(maxpos_q));
  assign ncap_s    = -cap_s;
  assign buy       = (dev > lim_s) && (pos_s < cap_s);
  assign sell      = (dev < nlim_s) && (pos_s > ncap_s);
  assign fire      = take_tick && full && cool_ok && (buy || sell);

  // Configuration writes.
  always_comb begin
    lim_d    = lim_q;
    size_d   = size_q;
    maxpos_d = maxpos_q;
    cool_d   = cool_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD:    lim_d    = LIM_W'(cfg_data_i[THR_W-1:0]) * LIM_W'(WINDOW);
        CFG_TRADE_SIZE:   size_d   = cfg_data_i[SIZE_W-1:0];
        CFG_MAX_POSITION: maxpos_d = cfg_data_i[MAXPOS_W-1:0];
        CFG_COOLDOWN:     cool_d   = cfg_data_i[COOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Window, sum and trade history update.
  always_comb begin
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    latest_x_d  = latest_x_q;
    last_tick_d = last_tick_q;
    if (take_print) begin
      sum_d      = sum_q + SUM_W'(pop_word_i.price)
                   - (full ? SUM_W'(win_q[WINDOW-1]) : '0);
      latest_x_d = pop_word_i.price_x;
      if (!full) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
    if (fire) begin
      last_tick_d = pop_word_i.tick;
    end
  end

  // Output register: a buy wins when both tests could hold.
  always_comb begin
    out_valid_d = out_valid_q;
    side_d      = side_q;
    qty_d       = qty_q;
    if (fire) begin
      out_valid_d = 1'b1;
      side_d      = buy ? SIDE_BUY : SIDE_SELL;
      qty_d       = size_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and configuration flops.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q       <= LIM_W'(THR_RST) * LIM_W'(WINDOW);
      size_q      <= SIZE_W'(SIZE_RST);
      maxpos_q    <= MAXPOS_W'(MAXPOS_RST);
      cool_q      <= COOL_W'(COOL_RST);
      cnt_q       <= '0;
      sum_q       <= '0;
      latest_x_q  <= '0;
      last_tick_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      lim_q       <= lim_d;
      size_q      <= size_d;
      maxpos_q    <= maxpos_d;
      cool_q      <= cool_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      latest_x_q  <= latest_x_d;
      last_tick_q <= last_tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Price shift line, newest at the head, oldest at the tail.
  always_ff @(posedge clk_i) begin
    if (take_print) begin
      win_q[0] <= pop_word_i.price;
      for (int i = 1; i < WINDOW; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  // Output payload flops.
  always_ff @(posedge clk_i) begin
    side_q <= side_d;
    qty_q  <= qty_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.side     = side_q;
  assign out_o.quantity = qty_q;

`ifndef NO_ASSERTIONS
  // The print count saturates at the window length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WINDOW))
    else $error("print count above window length");

  // A new order word only appears after a tick that traded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(fire))
    else $error("order word without a trade");

  // A trade records its tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (last_tick_q == $past(pop_word_i.tick)))
    else $error("trade tick not recorded");
`endif

endmodule

// ===== test/trade_trigger_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trade_trigger_checker: order predictor and scoreboard for the trade trigger
// Watches the input channel, the order channel and the register write port.
// It keeps its own price window, running sum and trade history, queues the
// order each accepted tick should produce, and compares every accepted order
// word field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module trade_trigger_checker import sdtt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sdtt_in_if                    words_i,
  sdtt_out_if                   orders_i,
  output int                    orders_due_o,
  output int                    mismatches_o
);

  typedef struct packed {
    logic              side;
    logic [SIZE_W-1:0] quantity;
  } order_t;

  // Ring of expected orders; far more slots than words can be in flight.
  localparam int ORDER_SLOTS = 64;

  // Shadow copies of the configuration registers.
  logic [THR_W-1:0]    threshold;
  logic [SIZE_W-1:0]   trade_size;
  logic [MAXPOS_W-1:0] max_position;
  logic [COOL_W-1:0]   cooldown;

  // Shadow window and trade history.
  logic [PRICE_W-1:0] price_hist [WINDOW];
  int                 next_slot;
  int                 prints_held;
  longint             price_total;
  logic [PRICE_W-1:0] last_print;
  logic [TICK_W-1:0]  last_fill_tick;

  order_t expected_orders [ORDER_SLOTS];
  int     order_wr;
  int     order_rd;
  int     mismatches;

  // Apply one accepted input word and queue the order it triggers, if any.
  task automatic predict_order(input logic cmd, input logic [PRICE_W-1:0] price,
                               input logic [TICK_W-1:0] tick,
                               input logic signed [POS_W-1:0] pos);
    longint deviation;
    longint margin;
    longint cap;
    longint held;
    if (cmd == OP_PRINT) begin
      // Once the window is full the oldest print drops out of the sum.
      if (prints_held >= WINDOW) begin
        price_total -= longint'(price_hist[next_slot]);
      end else begin
        prints_held++;
      end
      price_hist[next_slot] = price;
      price_total += longint'(price);
      last_print = price;
      next_slot = (next_slot + 1) % WINDOW;
      return;
    end
    // A tick only acts on a full window after the cooldown has run out.
    // The tick distance wraps modulo 2^64.
    if (prints_held < WINDOW) return;
    if ((tick - last_fill_tick) < TICK_W'(cooldown)) return;
    deviation = WINDOW * longint'(last_print) - price_total;
    margin    = WINDOW * longint'(threshold);
    cap       = longint'(max_position);
    held      = longint'(pos);
    // A deviation equal to the margin trades on neither side.
    if (deviation > margin && held < cap) begin
      expected_orders[order_wr % ORDER_SLOTS] = '{side: SIDE_BUY, quantity: trade_size};
      order_wr++;
      last_fill_tick = tick;
    end else if (deviation < -margin && held > -cap) begin
      expected_orders[order_wr % ORDER_SLOTS] = '{side: SIDE_SELL, quantity: trade_size};
      order_wr++;
      last_fill_tick = tick;
    end
  endtask

  // Track register writes, check order words, then predict from input words.
  always @(posedge clk_i or negedge rst_ni) begin
    order_t want;
    if (!rst_ni) begin
      threshold      = THR_W'(THR_RST);
      trade_size     = SIZE_W'(SIZE_RST);
      max_position   = MAXPOS_W'(MAXPOS_RST);
      cooldown       = COOL_W'(COOL_RST);
      next_slot      = 0;
      prints_held    = 0;
      price_total    = 0;
      last_print     = '0;
      last_fill_tick = '0;
      mismatches     = 0;
      order_wr       = 0;
      order_rd       = 0;
    end else begin
      // Values are cut to the register width; unused indexes do nothing.
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_THRESHOLD:    threshold    = cfg_data_i[THR_W-1:0];
          CFG_TRADE_SIZE:   trade_size   = cfg_data_i[SIZE_W-1:0];
          CFG_MAX_POSITION: max_position = cfg_data_i[MAXPOS_W-1:0];
          CFG_COOLDOWN:     cooldown     = cfg_data_i[COOL_W-1:0];
          default: ;
        endcase
      end
      if (orders_i.valid && orders_i.ready) begin
        if (order_wr == order_rd) begin
          $error("unexpected order word: side %0d, quantity %0d",
                 orders_i.side, orders_i.quantity);
          mismatches++;
        end else begin
          want = expected_orders[order_rd % ORDER_SLOTS];
          order_rd++;
          if (orders_i.side !== want.side) begin
            $error("side: expected %0d, actual %0d", want.side, orders_i.side);
            mismatches++;
          end
          if (orders_i.quantity !== want.quantity) begin
            $error("quantity: expected %0d, actual %0d", want.quantity,
                   orders_i.quantity);
            mismatches++;
          end
        end
      end
      if (words_i.valid && words_i.ready) begin
        predict_order(words_i.cmd, words_i.price, words_i.tick_number,
                      words_i.position);
      end
    end
    orders_due_o <= order_wr - order_rd;
    mismatches_o <= mismatches;
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench top for the moving-average trade trigger
// Drives a directed opening (empty window, price and position extremes,
// cooldown, threshold boundary, tick wraparound) and then random streams of
// prints and ticks under several register settings and idle patterns. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import sdtt_pkg::*;

  localparam int PRICE_MAX     = 2**PRICE_W - 1;
  localparam int POS_MAX       = 2**(POS_W-1) - 1;
  localparam int POS_MIN       = -(2**(POS_W-1));
  localparam int SEGMENTS      = 8;
  localparam int SEGMENT_WORDS = 171;
  localparam int DRAIN_CYCLES  = 8;
  localparam int QUIET_LIMIT   = 2000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int cur_cooldown = COOL_RST;
  int cur_max_position = MAXPOS_RST;
  int orders_due;
  int mismatches;
  int quiet_cycles = 0;

  sdtt_in_if  word_in ();
  sdtt_out_if order_out ();

  sma_deviation_trade_trigger dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (word_in),
    .out_o       (order_out)
  );

  trade_trigger_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .words_i      (word_in),
    .orders_i     (order_out),
    .orders_due_o (orders_due),
    .mismatches_o (mismatches)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Order receiver: stalls at random at the rate of the current phase.
  initial begin
    order_out.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      order_out.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: ends the run when no word moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (word_in.valid && word_in.ready) ||
        (order_out.valid && order_out.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("sma_deviation_trade_trigger: mismatch");
      $finish;
    end
  end

  // Offer one input word, after random idle cycles, and wait until taken.
  task automatic send_word(input logic cmd, input logic [PRICE_W-1:0] price,
                           input logic [TICK_W-1:0] tick,
                           input logic signed [POS_W-1:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      word_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    word_in.valid       <= 1'b1;
    word_in.cmd         <= cmd;
    word_in.price       <= price;
    word_in.tick_number <= tick;
    word_in.position    <= pos;
    do @(posedge clk_i); while (!word_in.ready);
  endtask

  // Drain the block, then write all four registers and one unused index.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] thr,
                              input logic [CFG_DATA_W-1:0] size,
                              input logic [CFG_DATA_W-1:0] max_pos,
                              input logic [CFG_DATA_W-1:0] cool);
    word_in.valid <= 1'b0;
    do @(posedge clk_i); while (orders_due != 0);
    // A tick that trades on neither side may still be in flight.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk_i);
    cfg_index <= CFG_TRADE_SIZE;
    cfg_data  <= size;
    @(posedge clk_i);
    cfg_index <= CFG_MAX_POSITION;
    cfg_data  <= max_pos;
    @(posedge clk_i);
    cfg_index <= CFG_COOLDOWN;
    cfg_data  <= cool;
    @(posedge clk_i);
    cfg_index <= CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, CFG_COOLDOWN + 1));
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_cooldown     = int'(cool[COOL_W-1:0]);
    cur_max_position = int'(max_pos[MAXPOS_W-1:0]);
  endtask

  initial begin
    int                      p;
    int                      mid_price;
    logic [TICK_W-1:0]       tick_now;
    logic signed [POS_W-1:0] pos;

    word_in.valid       = 1'b0;
    word_in.cmd         = OP_PRINT;
    word_in.price       = '0;
    word_in.tick_number = '0;
    word_in.position    = '0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_THRESHOLD;
    cfg_data            = '0;
    rst_ni              = 1'b0;
    mid_price           = 1000000;
    tick_now            = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening with the reset register values.
    send_word(OP_TICK, 0, 0, 0);              // empty window: nothing
    send_word(OP_PRINT, PRICE_W'(PRICE_MAX), 0, 0);
    send_word(OP_PRINT, 0, 0, 0);
    repeat (18) send_word(OP_PRINT, 1000, 0, 0);
    send_word(OP_TICK, 0, 3, 0);              // still within the cooldown
    send_word(OP_TICK, 0, 5, -500);           // sell held back by the cap
    send_word(OP_TICK, 0, 5, POS_W'(POS_MAX)); // sell
    send_word(OP_PRINT, 1000, 0, 0);
    send_word(OP_PRINT, 1000, 0, 0);
    send_word(OP_TICK, 0, 20, 0);             // flat window: no deviation
    // With a threshold of 19 one print 20 cents up lands exactly on it.
    program_regs(19, CFG_DATA_W'(SIZE_RST), CFG_DATA_W'(MAXPOS_RST),
                 CFG_DATA_W'(COOL_RST));
    send_word(OP_PRINT, 1020, 0, 0);
    send_word(OP_TICK, 0, 30, 0);             // at the threshold: nothing
    send_word(OP_PRINT, 2000, 0, 0);
    send_word(OP_TICK, 0, 40, 500);           // buy held back by the cap
    send_word(OP_TICK, 0, 40, 499);           // buy
    send_word(OP_TICK, 0, {TICK_W{1'b1}}, POS_W'(POS_MIN));

    // Random streams under several settings and idle patterns.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: program_regs(0, 1, 0, 0);
        1: program_regs(20'hFFFFF, 20'h0FFFF, 20'hFFFFF, 20'h0FFFF);
        // Bit 16 is cut off, so the trade size becomes zero.
        3: program_regs(CFG_DATA_W'($urandom_range(300)), 20'h10000,
                        CFG_DATA_W'($urandom_range(2000)),
                        CFG_DATA_W'($urandom_range(20)));
        default: program_regs(CFG_DATA_W'($urandom_range(300)),
                              CFG_DATA_W'($urandom_range(65535, 1)),
                              CFG_DATA_W'($urandom_range(2000)),
                              CFG_DATA_W'($urandom_range(20)));
      endcase
      case (seg / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      for (int n = 0; n < SEGMENT_WORDS; n++) begin
        if ($urandom_range(99) < 2) mid_price = int'($urandom_range(PRICE_MAX));
        if ($urandom_range(99) < 40) begin
          // Ticks mostly step around the cooldown, sometimes jump or wrap.
          case ($urandom_range(9))
            0: tick_now = {$urandom, $urandom};
            1: tick_now = tick_now + TICK_W'(cur_cooldown);
            2: tick_now = tick_now + TICK_W'(cur_cooldown) - 1;
            3: tick_now = tick_now + TICK_W'($urandom_range(1 << 20));
            default: tick_now = tick_now + TICK_W'($urandom_range(2 * cur_cooldown + 2));
          endcase
          case ($urandom_range(5))
            0: pos = POS_W'($urandom);
            1: pos = POS_W'(cur_max_position - int'($urandom_range(1)));
            2: pos = POS_W'(int'($urandom_range(1)) - cur_max_position);
            default: pos = POS_W'(int'($urandom_range(2 * cur_max_position + 4))
                                  - cur_max_position - 2);
          endcase
          send_word(OP_TICK, PRICE_W'($urandom), tick_now, pos);
        end else begin
          // Prints cluster around a drifting mean with spikes and outliers.
          case ($urandom_range(9))
            0: p = int'($urandom_range(PRICE_MAX));
            1: p = mid_price + int'($urandom_range(8000)) - 4000;
            default: p = mid_price + int'($urandom_range(60)) - 30;
          endcase
          if (p < 0) p = 0;
          else if (p > PRICE_MAX) p = PRICE_MAX;
          send_word(OP_PRINT, PRICE_W'(p), {$urandom, $urandom}, POS_W'($urandom));
        end
      end
    end

    word_in.valid <= 1'b0;
    do @(posedge clk_i); while (orders_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sma_deviation_trade_trigger: match");
    end else begin
      $display("sma_deviation_trade_trigger: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/sdtt_pkg.sv
src/sdtt_if.sv
src/sdtt_front.sv
src/sdtt_queue.sv
src/sdtt_back.sv
src/sma_deviation_trade_trigger.sv
test/trade_trigger_checker.sv
test/tb_top.sv
